// ----- hw/rtl/clock_tempo_tracker_step_counter_top_defines.svh -----
// Assertion macros for the clock tempo tracker.
// Included by the top level; needs nothing else.
`ifndef CLOCK_TEMPO_TRACKER_STEP_COUNTER_TOP_DEFINES_SVH
`define CLOCK_TEMPO_TRACKER_STEP_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ctt_pkg.sv -----
// Shared constants, types and helper functions of the clock tempo tracker.
// No dependencies.
package ctt_pkg;

    // Datapath sizes
    localparam int COUNT_WIDTH = 32;
    localparam int MAX_BEATS   = 32;
    localparam int BEAT_W      = $clog2(MAX_BEATS);
    localparam int LIM_W       = $clog2(MAX_BEATS + 1);
    localparam int REC_W       = 5;
    localparam int SUM_W       = COUNT_WIDTH + REC_W;
    localparam int TOT_W       = 2;

    // Register widths
    localparam int SR_W        = 18;
    localparam int BPC_W       = 6;
    localparam int WIN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_CYCLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_WINDOW  = 2'd2;

    // Register reset values
    localparam logic [SR_W-1:0]  SAMPLE_RATE_RST = 18'd48000;
    localparam logic [BPC_W-1:0] BPC_RST         = 6'd16;
    localparam logic [WIN_W-1:0] WINDOW_RST      = 5'd6;
    localparam logic [WIN_W-1:0] WINDOW_CAP      = 5'd16;
    localparam logic [TOT_W-1:0] TOTAL_SAT       = 2'd3;

    // Commands from the sequencer to the beat counter
    typedef struct packed {
        logic set_before;
        logic advance;
    } t_beat_cmd;

    // Effective beat count: zero acts as one, large values clip
    function automatic logic [LIM_W-1:0] beats_limit(input logic [BPC_W-1:0] bpc);
        logic [LIM_W-1:0] lim;
        if (bpc == '0) begin
            lim = LIM_W'(1);
        end else if (32'(bpc) > 32'(MAX_BEATS)) begin
            lim = LIM_W'(MAX_BEATS);
        end else begin
            lim = LIM_W'(bpc);
        end
        return lim;
    endfunction

    // Averaging window clipped so the gap sum cannot overflow
    function automatic logic [WIN_W-1:0] window_limit(input logic [WIN_W-1:0] win);
        return (win > WINDOW_CAP) ? WINDOW_CAP : win;
    endfunction

endpackage

// ----- hw/rtl/ctt_serial_div.sv -----
// Bit-serial restoring divider: gap sum over recent edge count.
// Depends on ctt_pkg.
module ctt_serial_div import ctt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SUM_W-1:0]       i_dividend,
    input  logic [REC_W-1:0]       i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [COUNT_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_shift;
    logic [REC_W-1:0] r_rem;
    logic [REC_W-1:0] r_div;

    logic [REC_W:0]   w_trial;
    logic             w_ge;
    logic [REC_W:0]   w_diff;

    // One quotient bit per cycle: bring down the next dividend bit and try
    assign w_trial = {r_rem, r_shift[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend/quotient shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[SUM_W-2:0], w_ge};
            r_rem   <= w_ge ? w_diff[REC_W-1:0] : w_trial[REC_W-1:0];
        end
    end

    // Empty window averages to zero
    assign o_quotient = (r_div == '0) ? '0 : r_shift[COUNT_WIDTH-1:0];
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

// ----- hw/rtl/ctt_beat.sv -----
// Beat position counter with wrap and before-first-beat marker.
// Depends on ctt_pkg.
module ctt_beat import ctt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_beat_cmd         i_cmd,
    input  logic [BPC_W-1:0]  i_beats_per_cycle,
    output logic [BEAT_W-1:0] o_beat_index,
    output logic              o_before_first
);

    logic [BEAT_W-1:0] r_idx;
    logic              r_before;

    logic [BEAT_W:0]   w_inc;
    logic [BEAT_W:0]   w_lim;

    assign w_inc = {1'b0, r_idx} + 1'b1;
    assign w_lim = (BEAT_W + 1)'(beats_limit(i_beats_per_cycle));

    // Reset edge parks the position; clock edge steps or wraps it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_before <= 1'b0;
        end else begin
            priority if (i_cmd.set_before) begin
                r_before <= 1'b1;
            end else if (i_cmd.advance) begin
                if (r_before) begin
                    r_idx    <= '0;
                    r_before <= 1'b0;
                end else if (w_inc >= w_lim) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= w_inc[BEAT_W-1:0];
                end
            end
        end
    end

    assign o_beat_index   = r_idx;
    assign o_before_first = r_before;

endmodule

// ----- hw/rtl/clock_tempo_tracker_step_counter_top.sv -----
// Clock tempo tracker top level: sequencer, tick counter, period estimate, output register.
// Depends on ctt_pkg, ctt_serial_div, ctt_beat and the assertion macro header.
//
// One request per sample tick. A tick without a clock edge passes S_TICK and S_OUT before
// the next acceptance; a clock edge during warm-up or after a long gap passes S_TICK, S_EDGE,
// S_WIN and S_OUT. Once the average is running, a clock edge also waits in S_DIV for the bit-serial
// divider that retires one quotient bit per cycle over the 37-bit gap sum. Results sit in an output
// register, so the next request is taken while the previous result waits to be read.
// Configuration writes take effect at once and must only come while the block is idle;
// writing the sample rate also reloads the period estimate with half the new rate.
`include "clock_tempo_tracker_step_counter_top_defines.svh"

module clock_tempo_tracker_step_counter_top import ctt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_clock_level,
    input  logic                   i_reset_level,
    // Output channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_playing,
    output logic                   o_beat_pulse,
    output logic                   o_downbeat,
    output logic [BEAT_W-1:0]      o_beat_position,
    output logic [COUNT_WIDTH-1:0] o_period_ticks
);

    localparam int LONG_W = SR_W + 3;
    localparam int GCMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_EDGE,
        S_DIV,
        S_WIN,
        S_OUT
    } t_state;

    t_state                 r_state;

    // Configuration
    logic [SR_W-1:0]        r_sample_rate;
    logic [BPC_W-1:0]       r_bpc;
    logic [WIN_W-1:0]       r_window;

    // Tracker state
    logic                   r_clk_in;
    logic                   r_rst_in;
    logic                   r_clock_prev;
    logic                   r_reset_prev;
    logic [COUNT_WIDTH-1:0] r_ticks;
    logic [COUNT_WIDTH-1:0] r_gap;
    logic [COUNT_WIDTH-1:0] r_period;
    logic [SUM_W-1:0]       r_sum;
    logic [REC_W-1:0]       r_recent;
    logic [TOT_W-1:0]       r_total;
    logic                   r_play;
    logic                   r_edge;

    // Output register
    logic                   r_out_valid;
    logic                   r_out_playing;
    logic                   r_out_pulse;
    logic                   r_out_down;
    logic [BEAT_W-1:0]      r_out_pos;
    logic [COUNT_WIDTH-1:0] r_out_period;

    logic [COUNT_WIDTH-1:0] w_ticks_inc;
    logic                   w_clock_edge;
    logic                   w_reset_edge;
    logic [REC_W-1:0]       w_recent_n;
    logic [TOT_W-1:0]       w_total_n;
    logic [LONG_W-1:0]      w_long_lim;
    logic                   w_long_gap;
    logic [SUM_W-1:0]       w_sum_n;
    logic [COUNT_WIDTH-1:0] w_eighth;
    logic                   w_out_load;

    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [COUNT_WIDTH-1:0] div_quotient;

    t_beat_cmd              beat_cmd;
    logic [BEAT_W-1:0]      beat_index;
    logic                   beat_before;

    // Tick count saturates at full scale
    assign w_ticks_inc  = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
    assign w_clock_edge = r_clk_in & ~r_clock_prev;
    assign w_reset_edge = r_rst_in & ~r_reset_prev;

    // Edge bookkeeping
    assign w_recent_n = r_recent + 1'b1;
    assign w_total_n  = (r_total == TOTAL_SAT) ? r_total : r_total + 1'b1;
    assign w_long_lim = {r_sample_rate, 2'b00} + LONG_W'(r_sample_rate);
    assign w_long_gap = r_play && (GCMP_W'(r_gap) > GCMP_W'(w_long_lim));
    assign w_sum_n    = r_sum + SUM_W'(r_gap);
    assign w_eighth   = COUNT_WIDTH'(r_sample_rate >> 3);

    assign div_start  = (r_state == S_EDGE) && !w_long_gap && (w_total_n == TOTAL_SAT);

    assign beat_cmd.set_before = (r_state == S_TICK) && w_reset_edge;
    assign beat_cmd.advance    = (r_state == S_WIN);

    // Result register takes a new result when empty or being drained
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    ctt_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_sum_n),
        .i_divisor  (w_recent_n),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    ctt_beat u_beat (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (beat_cmd),
        .i_beats_per_cycle (r_bpc),
        .o_beat_index      (beat_index),
        .o_before_first    (beat_before)
    );

    // Sequencer, tracker state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sample_rate <= SAMPLE_RATE_RST;
            r_bpc         <= BPC_RST;
            r_window      <= WINDOW_RST;
            r_clk_in      <= 1'b0;
            r_rst_in      <= 1'b0;
            r_clock_prev  <= 1'b0;
            r_reset_prev  <= 1'b0;
            r_ticks       <= '0;
            r_gap         <= '0;
            r_period      <= COUNT_WIDTH'(SAMPLE_RATE_RST >> 1);
            r_sum         <= '0;
            r_recent      <= '0;
            r_total       <= '0;
            r_play        <= 1'b0;
            r_edge        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_playing <= 1'b0;
            r_out_pulse   <= 1'b0;
            r_out_down    <= 1'b0;
            r_out_pos     <= '0;
            r_out_period  <= '0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_RATE: begin
                        r_sample_rate <= i_cfg_data[SR_W-1:0];
                        r_period      <= COUNT_WIDTH'(i_cfg_data[SR_W-1:0] >> 1);
                    end
                    CFG_BEATS_PER_CYCLE: r_bpc    <= i_cfg_data[BPC_W-1:0];
                    CFG_AVERAGE_WINDOW:  r_window <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            // Output handshake
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_clk_in <= i_clock_level;
                        r_rst_in <= i_reset_level;
                        r_state  <= S_TICK;
                    end
                end
                // Count the tick, note edges, check the play timeout
                S_TICK: begin
                    r_clock_prev <= r_clk_in;
                    r_reset_prev <= r_rst_in;
                    r_edge       <= w_clock_edge;
                    if (r_play && (w_ticks_inc > r_period)) begin
                        r_play <= 1'b0;
                    end
                    if (w_clock_edge) begin
                        r_gap   <= w_ticks_inc;
                        r_ticks <= '0;
                        r_state <= S_EDGE;
                    end else begin
                        r_ticks <= w_ticks_inc;
                        r_state <= S_OUT;
                    end
                end
                // Clock edge: restart after a long gap, else accumulate
                S_EDGE: begin
                    r_play <= 1'b1;
                    if (w_long_gap) begin
                        r_total  <= '0;
                        r_recent <= '0;
                        r_sum    <= '0;
                        r_period <= w_eighth;
                        r_state  <= S_WIN;
                    end else begin
                        r_total  <= w_total_n;
                        r_recent <= w_recent_n;
                        if (w_total_n == TOTAL_SAT) begin
                            r_sum   <= w_sum_n;
                            r_state <= S_DIV;
                        end else begin
                            r_period <= w_eighth;
                            r_state  <= S_WIN;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_period <= div_quotient;
                        r_state  <= S_WIN;
                    end
                end
                // Window restart; beat advances this cycle
                S_WIN: begin
                    if (r_recent > window_limit(r_window)) begin
                        r_recent <= '0;
                        r_sum    <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_playing <= r_play;
                        r_out_pulse   <= r_edge;
                        r_out_down    <= r_edge && (beat_index == '0);
                        r_out_pos     <= beat_before ? '0 : beat_index;
                        r_out_period  <= r_period;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_playing       = r_out_playing;
    assign o_beat_pulse    = r_out_pulse;
    assign o_downbeat      = r_out_down;
    assign o_beat_position = r_out_pos;
    assign o_period_ticks  = r_out_period;

    // Checks
    `CTT_ASSERT_NOW(a_div_idle_at_start, i_clk, i_rst_n, div_start, !div_busy, "divider restarted while busy")
    `CTT_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, div_start, div_busy, "divider did not start")
    `CTT_ASSERT_NOW(a_down_on_zero, i_clk, i_rst_n, o_valid && o_downbeat, o_beat_pulse && (o_beat_position == '0), "downbeat off position zero")
    `CTT_ASSERT_NOW(a_pulse_plays, i_clk, i_rst_n, o_valid && o_beat_pulse, o_playing, "beat without play")

endmodule

// ----- tb/sv/clock_tempo_tracker_step_counter_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the clock tempo tracker and beat counter.
// Needs ctt_pkg and clock_tempo_tracker_step_counter_top; carries its own tempo predictor.
module clock_tempo_tracker_step_counter_top_tb import ctt_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          DIR_N       = 20;
    localparam int          PHASE_N     = 10;
    // index with no register behind it, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One result of the block
    typedef struct packed {
        logic                   playing;
        logic                   pulse;
        logic                   down;
        logic [BEAT_W-1:0]      pos;
        logic [COUNT_WIDTH-1:0] period;
    } t_tick_result;

    // Directed request, with a hand-written expectation where typed is set
    typedef struct packed {
        logic         clk_lv;
        logic         rst_lv;
        logic         typed;
        t_tick_result want;
    } t_tick_row;

    // Register setting and clock shape of one random phase
    typedef struct packed {
        logic [SR_W-1:0]  rate;
        logic [BPC_W-1:0] beats;
        logic [WIN_W-1:0] window;
        logic [7:0]       half;
        logic [11:0]      count;
    } t_phase;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_CHOKE} t_sink_mode;

    // Directed part runs on the reset register values
    localparam t_tick_row DIR_ROWS [DIR_N] = '{
        '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 32'd24000}}, // after reset
        '{1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0, 5'd1, 32'd6000}},  // first edge: eighth second
        '{1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd1, 32'd6000}},
        '{1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 5'd0, 32'd6000}},  // reset and clock together
        '{1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 32'd6000}},
        '{1'b1, 1'b0, 1'b0, '0},                                   // averaging starts
        '{1'b0, 1'b0, 1'b0, '0},                                   // play times out
        '{1'b0, 1'b1, 1'b0, '0},                                   // reset edge alone
        '{1'b1, 1'b1, 1'b0, '0},                                   // lands on downbeat
        '{1'b1, 1'b1, 1'b0, '0},                                   // held high, no edge
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},                                   // window restarts
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0}
    };

    // rate, beats, window, half clock period in ticks, request count
    localparam t_phase PHASES [PHASE_N] = '{
        '{18'd3,      6'd4,  5'd3,  8'd9,  12'd220}, // gaps around the five-second limit
        '{18'd1000,   6'd1,  5'd1,  8'd4,  12'd160}, // low extremes
        '{18'd192000, 6'd32, 5'd16, 8'd6,  12'd200}, // high extremes
        '{18'd0,      6'd0,  5'd0,  8'd3,  12'd160}, // zero rate, beats and window
        '{18'h3FFFF,  6'd63, 5'd31, 8'd5,  12'd200}, // beyond range, clipped
        '{18'd2,      6'd7,  5'd4,  8'd6,  12'd200},
        '{18'd48000,  6'd3,  5'd6,  8'd3,  12'd140}, // beat count below position
        '{18'd5,      6'd33, 5'd17, 8'd14, 12'd200},
        '{18'd1,      6'd2,  5'd2,  8'd3,  12'd180},
        '{18'd8,      6'd12, 5'd8,  8'd22, 12'd220}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_clock_level;
    logic                   i_reset_level;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_playing;
    logic                   o_beat_pulse;
    logic                   o_downbeat;
    logic [BEAT_W-1:0]      o_beat_position;
    logic [COUNT_WIDTH-1:0] o_period_ticks;

    // Tracker state as predicted
    logic [SR_W-1:0]        rate_reg;
    logic [BPC_W-1:0]       beats_reg;
    logic [WIN_W-1:0]       window_reg;
    logic [COUNT_WIDTH-1:0] since_edge;
    logic [COUNT_WIDTH-1:0] period_est;
    logic [SUM_W-1:0]       gap_total;
    logic [REC_W-1:0]       recent_cnt;
    logic [TOT_W-1:0]       total_cnt;
    logic                   play_on;
    logic [BEAT_W-1:0]      beat_idx;
    logic                   pre_first;
    logic                   clk_seen;
    logic                   rst_seen;

    t_tick_result pending_beats [$];
    int           mismatches = 0;
    int           sent_count = 0;
    int unsigned  cycles_run = 0;

    clock_tempo_tracker_step_counter_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_clock_level   (i_clock_level),
        .i_reset_level   (i_reset_level),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_playing       (o_playing),
        .o_beat_pulse    (o_beat_pulse),
        .o_downbeat      (o_downbeat),
        .o_beat_position (o_beat_position),
        .o_period_ticks  (o_period_ticks)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // One sample tick through the tempo tracker
    function automatic t_tick_result predict_tick(input logic c_lv, input logic r_lv);
        t_tick_result res;
        logic         rise_c;
        logic         rise_r;
        logic         down;
        logic [63:0]  gap;
        logic [63:0]  win;
        logic [63:0]  lim;
        logic [63:0]  nxt;
        rise_c = c_lv & ~clk_seen;
        rise_r = r_lv & ~rst_seen;
        down   = 1'b0;
        if (since_edge != '1) since_edge = since_edge + 1'b1;
        if (rise_r) pre_first = 1'b1;
        rst_seen = r_lv;
        if (play_on && since_edge > period_est) play_on = 1'b0;
        if (rise_c) begin
            gap        = 64'(since_edge);
            since_edge = '0;
            win        = (window_reg > 5'd16) ? 64'd16 : 64'(window_reg);
            recent_cnt = recent_cnt + 1'b1;
            if (total_cnt < 2'd3) total_cnt = total_cnt + 1'b1;
            // long gap while playing: back to warm-up
            if (play_on && gap > 64'(rate_reg) * 64'd5) begin
                total_cnt  = '0;
                recent_cnt = '0;
                gap_total  = '0;
            end
            if (total_cnt > 2'd2) begin
                gap_total  = SUM_W'(64'(gap_total) + gap);
                period_est = (recent_cnt != '0) ?
                             COUNT_WIDTH'(64'(gap_total) / 64'(recent_cnt)) : '0;
            end else begin
                period_est = COUNT_WIDTH'(rate_reg / 8);
            end
            if (64'(recent_cnt) > win) begin
                recent_cnt = '0;
                gap_total  = '0;
            end
            play_on = 1'b1;
            // beat advance, wrapping at the clipped beat count
            if (pre_first) begin
                beat_idx  = '0;
                pre_first = 1'b0;
            end else begin
                lim = (beats_reg == '0) ? 64'd1 :
                      (64'(beats_reg) > 64'(MAX_BEATS)) ? 64'(MAX_BEATS) : 64'(beats_reg);
                nxt = 64'(beat_idx) + 64'd1;
                beat_idx = (nxt >= lim) ? '0 : BEAT_W'(nxt);
            end
            down = (beat_idx == '0);
        end
        clk_seen = c_lv;
        res.playing = play_on;
        res.pulse   = rise_c;
        res.down    = down;
        res.pos     = pre_first ? '0 : beat_idx;
        res.period  = period_est;
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycles_run);
        mismatches++;
    endtask

    // Offer one request and record its expected result once taken
    task automatic send_tick(input logic c_lv, input logic r_lv, input logic typed,
                             input t_tick_result want);
        t_tick_result pred;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_clock_level <= c_lv;
        i_reset_level <= r_lv;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pred = predict_tick(c_lv, r_lv);
        pending_beats.push_back(typed ? want : pred);
        sent_count++;
    endtask

    // Register write, mirrored into the predictor when the block takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SAMPLE_RATE: begin
                rate_reg   = data[SR_W-1:0];
                period_est = COUNT_WIDTH'(rate_reg / 2);
            end
            CFG_BEATS_PER_CYCLE: beats_reg  = data[BPC_W-1:0];
            CFG_AVERAGE_WINDOW:  window_reg = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid and wait until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    // Stimulus: reset, directed table, then random phases
    initial begin : stimulus
        int                    h;
        int                    gap_len;
        int                    burst_left;
        int                    clk_run;
        int                    rst_run;
        logic                  c_now;
        logic                  c_lv;
        logic                  r_lv;
        logic [CFG_DATA_W-1:0] d;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_clock_level = 1'b0;
        i_reset_level = 1'b0;
        rate_reg      = SAMPLE_RATE_RST;
        beats_reg     = BPC_RST;
        window_reg    = WINDOW_RST;
        since_edge    = '0;
        period_est    = COUNT_WIDTH'(SAMPLE_RATE_RST / 2);
        gap_total     = '0;
        recent_cnt    = '0;
        total_cnt     = '0;
        play_on       = 1'b0;
        beat_idx      = '0;
        pre_first     = 1'b0;
        clk_seen      = 1'b0;
        rst_seen      = 1'b0;
        c_now         = 1'b0;
        clk_run       = 0;
        rst_run       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
            send_tick(DIR_ROWS[k].clk_lv, DIR_ROWS[k].rst_lv, DIR_ROWS[k].typed,
                      DIR_ROWS[k].want);

        for (int p = 0; p < PHASE_N; p++) begin
            // registers change only with the block idle; the sender waits here
            drain_results();
            d = PHASES[p].rate;
            write_reg(CFG_SAMPLE_RATE, d);
            d = CFG_DATA_W'($urandom);
            d[BPC_W-1:0] = PHASES[p].beats;
            write_reg(CFG_BEATS_PER_CYCLE, d);
            d = CFG_DATA_W'($urandom);
            d[WIN_W-1:0] = PHASES[p].window;
            write_reg(CFG_AVERAGE_WINDOW, d);
            if (p == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            h          = int'(PHASES[p].half);
            burst_left = 0;
            for (int n = 0; n < int'(PHASES[p].count); n++) begin
                // sender bursts, sometimes back to back
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap_len > 0) begin
                        @(negedge i_clk);
                        i_valid <= 1'b0;
                        repeat (gap_len - 1) @(negedge i_clk);
                    end
                end
                burst_left--;
                // jittered clock with rare long pauses
                if (clk_run == 0) begin
                    c_now = ~c_now;
                    if (!c_now && $urandom_range(0, 15) == 0)
                        clk_run = $urandom_range(4 * h, 8 * h);
                    else
                        clk_run = $urandom_range(h - 2, h + 2);
                    if (c_now && $urandom_range(0, 9) == 0) rst_run = $urandom_range(1, 3);
                end
                clk_run--;
                c_lv = c_now;
                if ($urandom_range(0, 19) == 0) c_lv = ~c_lv; // glitch
                if (rst_run == 0 && $urandom_range(0, 59) == 0) rst_run = $urandom_range(1, 4);
                r_lv = (rst_run != 0);
                if (rst_run != 0) rst_run--;
                send_tick(c_lv, r_lv, 1'b0, '0);
            end
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: changing stall patterns, plus one long hold-off
    initial begin : result_sink
        int         run_left;
        int         stall_left;
        int         hold_left;
        bit         held;
        t_sink_mode mode;
        i_ready    = 1'b0;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        mode       = SINK_OPEN;
        forever begin
            @(negedge i_clk);
            if (!held && sent_count >= 300) begin
                hold_left = 400;
                held      = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode     = t_sink_mode'($urandom_range(0, 2));
                    run_left = $urandom_range(10, 80);
                end
                run_left--;
                case (mode)
                    SINK_OPEN: i_ready <= 1'b1;
                    SINK_COIN: i_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            i_ready <= 1'b0;
                        end else begin
                            stall_left = $urandom_range(1, 12);
                            i_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_tick_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch("result with nothing pending", 64'(o_period_ticks), 64'd0);
            end else begin
                want = pending_beats.pop_front();
                if (o_playing !== want.playing)
                    flag_mismatch("playing", 64'(o_playing), 64'(want.playing));
                if (o_beat_pulse !== want.pulse)
                    flag_mismatch("beat_pulse", 64'(o_beat_pulse), 64'(want.pulse));
                if (o_downbeat !== want.down)
                    flag_mismatch("downbeat", 64'(o_downbeat), 64'(want.down));
                if (o_beat_position !== want.pos)
                    flag_mismatch("beat_position", 64'(o_beat_position), 64'(want.pos));
                if (o_period_ticks !== want.period)
                    flag_mismatch("period_ticks", 64'(o_period_ticks), 64'(want.period));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
